>>> hdl/crpe_pkg.sv
// ============================================================================
// crpe_pkg
// Shared widths, constants, tables and lane types for the Cartesian to
// rho/phi/eta converter.
// ============================================================================
`default_nettype none

package crpe_pkg;

    // Top-level parameter defaults
    localparam int COORD_BITS_DEF    = 20;
    localparam int CORDIC_STAGES_DEF = 16;

    // Square-root lanes: 64-bit radicand, 32-bit root
    localparam int SQRT_IN_W = 64;
    localparam int SQRT_BITS = 32;
    localparam int RAD_FRAC  = 32;   // fraction bits + coordinate bits

    // CORDIC datapath
    localparam int CORDIC_W     = 58;
    localparam int CORDIC_SCALE = 56;
    localparam int ANGLE_W      = 32;
    localparam int ATAN_LEN     = 24;
    localparam logic [ANGLE_W-1:0] PI_Q31 = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_RND = 32'h0000_8000;

    // atan(2^-i) in units of pi/2^31
    localparam logic [ANGLE_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Fixed-point log2
    localparam int LOG_IN_W   = 33;
    localparam int LZ_LEVELS  = 6;
    localparam int LZ_CNT_W   = 6;
    localparam int LOG_MANT   = 31;
    localparam int LOG_FRAC   = 20;
    localparam int LOG_EXP_W  = 6;
    localparam int LOG_W      = LOG_EXP_W + LOG_FRAC;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
    localparam int PROD_W     = LOG_W + 32;
    localparam int ETA_SHIFT  = 40;
    localparam int MAG_W      = PROD_W + 1 - ETA_SHIFT;

    // Result fields
    localparam int AZ_W  = 16;
    localparam int ETA_W = 16;
    localparam logic [AZ_W-1:0]  AZ_NEG_PI   = 16'h8000;
    localparam logic [ETA_W-1:0] ETA_POS_MAX = 16'h7FFF;
    localparam logic [ETA_W-1:0] ETA_NEG_MAX = 16'h8000;
    localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_W'(32767);
    localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(32768);

    typedef struct packed {
        logic [SQRT_IN_W-1:0] rem;
        logic [SQRT_BITS-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]         acc;
    } t_cordic;

    typedef struct packed {
        logic [LOG_IN_W-1:0] n;
        logic [LZ_CNT_W-1:0] cnt;
    } t_norm;

    typedef struct packed {
        logic [LOG_MANT-1:0]  m;
        logic [LOG_FRAC-1:0]  frac;
        logic [LOG_EXP_W-1:0] e;
    } t_log_lane;

    typedef struct packed {
        logic axis;
        logic z_neg;
        logic z_zero;
    } t_flags;

endpackage

`default_nettype wire

>>> hdl/crpe_sqrt_cell.sv
// ============================================================================
// crpe_sqrt_cell
// One bit of a restoring integer square root: tries to set root bit BIT.
// ============================================================================
`default_nettype none

module crpe_sqrt_cell
    import crpe_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic  i_clk,
    input  t_sqrt i_lane,
    output t_sqrt o_lane
);

    logic [SQRT_IN_W+1:0] w_trial;
    logic                 w_fit;
    t_sqrt                r_lane;

    // (2*root + 2^BIT) * 2^BIT against the remainder
    always_comb begin
        w_trial = ((SQRT_IN_W+2)'(i_lane.root) << (BIT + 1))
                + ((SQRT_IN_W+2)'(1) << (2 * BIT));
        w_fit   = ({2'b00, i_lane.rem} >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (w_fit) begin
            r_lane.rem  <= i_lane.rem - w_trial[SQRT_IN_W-1:0];
            r_lane.root <= i_lane.root | (SQRT_BITS'(1) << BIT);
        end else begin
            r_lane <= i_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

>>> hdl/crpe_cordic_cell.sv
// ============================================================================
// crpe_cordic_cell
// One vectoring CORDIC micro-rotation, drives y toward zero.
// ============================================================================
`default_nettype none

module crpe_cordic_cell
    import crpe_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  t_cordic i_lane,
    output t_cordic o_lane
);

    logic signed [CORDIC_W-1:0] w_x;
    logic signed [CORDIC_W-1:0] w_y;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    t_cordic                    r_lane;

    always_comb begin
        w_x  = i_lane.x;
        w_y  = i_lane.y;
        w_xs = w_x >>> STAGE;
        w_ys = w_y >>> STAGE;
    end

    // y >= 0 turns clockwise
    always_ff @(posedge i_clk) begin
        if (!w_y[CORDIC_W-1]) begin
            r_lane.x   <= w_x + w_ys;
            r_lane.y   <= w_y - w_xs;
            r_lane.acc <= i_lane.acc + ATAN_TAB[STAGE];
        end else begin
            r_lane.x   <= w_x - w_ys;
            r_lane.y   <= w_y + w_xs;
            r_lane.acc <= i_lane.acc - ATAN_TAB[STAGE];
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

>>> hdl/crpe_norm_cell.sv
// ============================================================================
// crpe_norm_cell
// One level of the leading-one normalizer: shifts left by SHIFT when the
// top SHIFT bits are all zero, and counts the shift.
// ============================================================================
`default_nettype none

module crpe_norm_cell
    import crpe_pkg::*;
#(
    parameter int SHIFT = 1
) (
    input  logic  i_clk,
    input  t_norm i_lane,
    output t_norm o_lane
);

    t_norm r_lane;

    always_ff @(posedge i_clk) begin
        if (i_lane.n[LOG_IN_W-1 -: SHIFT] == '0) begin
            r_lane.n   <= i_lane.n << SHIFT;
            r_lane.cnt <= i_lane.cnt + LZ_CNT_W'(SHIFT);
        end else begin
            r_lane <= i_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

>>> hdl/crpe_log_cell.sv
// ============================================================================
// crpe_log_cell
// One fraction bit of log2 by squaring a Q30 mantissa.
// ============================================================================
`default_nettype none

module crpe_log_cell
    import crpe_pkg::*;
(
    input  logic      i_clk,
    input  t_log_lane i_lane,
    output t_log_lane o_lane
);

    logic [2*LOG_MANT-1:0] w_sq;
    logic [LOG_MANT:0]     w_top;
    t_log_lane             r_lane;

    // m*m in Q30, one more bit ahead of the point means the bit is set
    always_comb begin
        w_sq  = (2*LOG_MANT)'(i_lane.m) * (2*LOG_MANT)'(i_lane.m);
        w_top = w_sq[2*LOG_MANT-1 -: LOG_MANT+1];
    end

    always_ff @(posedge i_clk) begin
        r_lane.m    <= w_top[LOG_MANT] ? w_top[LOG_MANT:1] : w_top[LOG_MANT-1:0];
        r_lane.frac <= {i_lane.frac[LOG_FRAC-2:0], w_top[LOG_MANT]};
        r_lane.e    <= i_lane.e;
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

>>> hdl/cartesian_to_rho_phi_eta_top.sv
// ============================================================================
// cartesian_to_rho_phi_eta_top
// Hit position to 3D radius, transverse radius, azimuth and pseudorapidity.
// ============================================================================
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  hit in   | i_pos_x, i_pos_y, i_pos_z               | start, busy
//  result   | o_radius_3d, o_radius_transverse,       | o_valid (one cycle)
//           | o_azimuth, o_pseudorapidity, o_on_axis  |
//
//  One beat in per clock, busy is never raised. Each beat passes the abs,
//  square and sum registers, the 32-cell square-root chain, the normalizer,
//  the 20-cell log2 squaring chain, eta scaling and the output register.
//  Reset clears only the valid pipeline; no result beat follows reset
//  until a new beat goes in. Results cannot be held off.
// ============================================================================
`default_nettype none

module cartesian_to_rho_phi_eta_top
    import crpe_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    output logic                         o_valid,
    output logic [COORD_BITS-1:0]        o_radius_3d,
    output logic [COORD_BITS-1:0]        o_radius_transverse,
    output logic signed [AZ_W-1:0]       o_azimuth,
    output logic signed [ETA_W-1:0]      o_pseudorapidity,
    output logic                         o_on_axis
);

    localparam int FB     = RAD_FRAC - COORD_BITS;
    localparam int SQW    = 2 * COORD_BITS;
    localparam int LAT    = SQRT_BITS + LZ_LEVELS + LOG_FRAC + 7;
    localparam int N_FLG  = LAT - 1;
    localparam int N_AZ   = SQRT_BITS + 3;
    localparam int N_RAD  = LAT - 4 - SQRT_BITS;
    localparam int N_ANG  = LAT - 2 - CORDIC_STAGES;

    logic w_accept;

    // ---------------- front end: abs, flags, CORDIC pre-rotation ----------
    logic [COORD_BITS-1:0]      n_ax, n_ay, n_az;
    t_flags                     n_flags;
    logic signed [CORDIC_W-1:0] w_xe, w_ye;
    t_cordic                    n_cor;

    logic [COORD_BITS-1:0] r_ax, r_ay;
    logic [COORD_BITS-1:0] r_az_dly [0:N_AZ-1];
    t_flags                r_flg_dly [0:N_FLG-1];
    t_cordic               r_cor;
    logic [SQW-1:0]        r_sqx, r_sqy, r_sqz;
    logic [SQRT_IN_W-1:0]  r_st, r_s3;
    logic [LAT-1:0]        r_vld;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_comb begin
        n_ax = i_pos_x[COORD_BITS-1] ? (~i_pos_x + 1'b1) : i_pos_x;
        n_ay = i_pos_y[COORD_BITS-1] ? (~i_pos_y + 1'b1) : i_pos_y;
        n_az = i_pos_z[COORD_BITS-1] ? (~i_pos_z + 1'b1) : i_pos_z;
        n_flags.axis   = (i_pos_x == '0) && (i_pos_y == '0);
        n_flags.z_neg  = i_pos_z[COORD_BITS-1];
        n_flags.z_zero = (i_pos_z == '0);
        w_xe = {{(CORDIC_W-COORD_BITS){i_pos_x[COORD_BITS-1]}}, i_pos_x}
               <<< (CORDIC_SCALE - COORD_BITS);
        w_ye = {{(CORDIC_W-COORD_BITS){i_pos_y[COORD_BITS-1]}}, i_pos_y}
               <<< (CORDIC_SCALE - COORD_BITS);
        // left half plane: turn by pi first
        if (i_pos_x[COORD_BITS-1]) begin
            n_cor.x   = -w_xe;
            n_cor.y   = -w_ye;
            n_cor.acc = PI_Q31;
        end else begin
            n_cor.x   = w_xe;
            n_cor.y   = w_ye;
            n_cor.acc = '0;
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // squares and sums
    always_ff @(posedge i_clk) begin
        r_ax  <= n_ax;
        r_ay  <= n_ay;
        r_cor <= n_cor;
        r_sqx <= SQW'(r_ax) * SQW'(r_ax);
        r_sqy <= SQW'(r_ay) * SQW'(r_ay);
        r_sqz <= SQW'(r_az_dly[0]) * SQW'(r_az_dly[0]);
        r_st  <= (SQRT_IN_W'(r_sqx) + SQRT_IN_W'(r_sqy)) << (2 * FB);
        r_s3  <= (SQRT_IN_W'(r_sqx) + SQRT_IN_W'(r_sqy) + SQRT_IN_W'(r_sqz))
                 << (2 * FB);
    end

    // side-band delay lines
    always_ff @(posedge i_clk) begin
        r_az_dly[0]  <= n_az;
        r_flg_dly[0] <= n_flags;
        for (int k = 1; k < N_AZ; k++) r_az_dly[k] <= r_az_dly[k-1];
        for (int k = 1; k < N_FLG; k++) r_flg_dly[k] <= r_flg_dly[k-1];
    end

    // ---------------- square-root chains ----------------------------------
    t_sqrt w_rt [0:SQRT_BITS];
    t_sqrt w_r3 [0:SQRT_BITS];

    assign w_rt[0] = '{rem: r_st, root: '0};
    assign w_r3[0] = '{rem: r_s3, root: '0};

    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
        crpe_sqrt_cell #(.BIT(SQRT_BITS - 1 - j)) u_rt (
            .i_clk (i_clk), .i_lane(w_rt[j]), .o_lane(w_rt[j+1])
        );
        crpe_sqrt_cell #(.BIT(SQRT_BITS - 1 - j)) u_r3 (
            .i_clk (i_clk), .i_lane(w_r3[j]), .o_lane(w_r3[j+1])
        );
    end

    // ---------------- CORDIC chain ----------------------------------------
    t_cordic            w_cor [0:CORDIC_STAGES];
    logic [ANGLE_W-1:0] r_ang_dly [0:N_ANG-1];

    assign w_cor[0] = r_cor;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        crpe_cordic_cell #(.STAGE(i)) u_cell (
            .i_clk (i_clk), .i_lane(w_cor[i]), .o_lane(w_cor[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_ang_dly[0] <= w_cor[CORDIC_STAGES].acc;
        for (int k = 1; k < N_ANG; k++) r_ang_dly[k] <= r_ang_dly[k-1];
    end

    // ---------------- log inputs and radii --------------------------------
    logic [LOG_IN_W-1:0]   r_la_in, r_lr_in;
    logic [COORD_BITS-1:0] r_r3_dly [0:N_RAD-1];
    logic [COORD_BITS-1:0] r_rt_dly [0:N_RAD-1];

    always_ff @(posedge i_clk) begin
        r_la_in <= (LOG_IN_W'(r_az_dly[N_AZ-1]) << FB)
                 + LOG_IN_W'(w_r3[SQRT_BITS].root);
        r_lr_in <= LOG_IN_W'(w_rt[SQRT_BITS].root);
        r_r3_dly[0] <= w_r3[SQRT_BITS].root[SQRT_BITS-1:FB];
        r_rt_dly[0] <= w_rt[SQRT_BITS].root[SQRT_BITS-1:FB];
        for (int k = 1; k < N_RAD; k++) begin
            r_r3_dly[k] <= r_r3_dly[k-1];
            r_rt_dly[k] <= r_rt_dly[k-1];
        end
    end

    // ---------------- normalizers -----------------------------------------
    t_norm w_na [0:LZ_LEVELS];
    t_norm w_nr [0:LZ_LEVELS];

    assign w_na[0] = '{n: r_la_in, cnt: '0};
    assign w_nr[0] = '{n: r_lr_in, cnt: '0};

    for (genvar k = 0; k < LZ_LEVELS; k++) begin : g_norm
        crpe_norm_cell #(.SHIFT(1 << (LZ_LEVELS - 1 - k))) u_na (
            .i_clk (i_clk), .i_lane(w_na[k]), .o_lane(w_na[k+1])
        );
        crpe_norm_cell #(.SHIFT(1 << (LZ_LEVELS - 1 - k))) u_nr (
            .i_clk (i_clk), .i_lane(w_nr[k]), .o_lane(w_nr[k+1])
        );
    end

    // ---------------- log2 squaring chains --------------------------------
    t_log_lane w_la [0:LOG_FRAC];
    t_log_lane w_lr [0:LOG_FRAC];

    // exponent is the leading-one position
    assign w_la[0] = '{m:    w_na[LZ_LEVELS].n[LOG_IN_W-1 -: LOG_MANT],
                       frac: '0,
                       e:    LOG_EXP_W'(LOG_IN_W - 1) - w_na[LZ_LEVELS].cnt};
    assign w_lr[0] = '{m:    w_nr[LZ_LEVELS].n[LOG_IN_W-1 -: LOG_MANT],
                       frac: '0,
                       e:    LOG_EXP_W'(LOG_IN_W - 1) - w_nr[LZ_LEVELS].cnt};

    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
        crpe_log_cell u_la (.i_clk(i_clk), .i_lane(w_la[k]), .o_lane(w_la[k+1]));
        crpe_log_cell u_lr (.i_clk(i_clk), .i_lane(w_lr[k]), .o_lane(w_lr[k+1]));
    end

    // ---------------- eta scaling -----------------------------------------
    logic [LOG_W-1:0]  w_la_val, w_lr_val;
    logic [LOG_W-1:0]  r_d;
    logic [PROD_W-1:0] r_prod;

    assign w_la_val = {w_la[LOG_FRAC].e, w_la[LOG_FRAC].frac};
    assign w_lr_val = {w_lr[LOG_FRAC].e, w_lr[LOG_FRAC].frac};

    always_ff @(posedge i_clk) begin
        r_d    <= (w_la_val > w_lr_val) ? (w_la_val - w_lr_val) : '0;
        r_prod <= PROD_W'(r_d) * PROD_W'(LN2_Q32);
    end

    // ---------------- output stage ----------------------------------------
    logic [PROD_W:0]       w_rnd;
    logic [MAG_W-1:0]      w_mag;
    t_flags                w_flg;
    logic [ANGLE_W-1:0]    w_ang;
    logic [ETA_W-1:0]      n_eta;
    logic [AZ_W-1:0]       n_az_out;

    logic [COORD_BITS-1:0] r_r3_out, r_rt_out;
    logic [AZ_W-1:0]       r_az_out;
    logic [ETA_W-1:0]      r_eta_out;
    logic                  r_axis_out;

    always_comb begin
        w_rnd    = (PROD_W+1)'(r_prod) + ((PROD_W+1)'(1) << (ETA_SHIFT - 1));
        w_mag    = w_rnd[PROD_W -: MAG_W];
        w_flg    = r_flg_dly[N_FLG-1];
        w_ang    = r_ang_dly[N_ANG-1] + ANGLE_RND;
        n_az_out = w_flg.axis ? AZ_NEG_PI : w_ang[ANGLE_W-1 -: AZ_W];
        if (w_flg.z_zero) begin
            n_eta = '0;
        end else if (w_flg.axis) begin
            n_eta = w_flg.z_neg ? ETA_NEG_MAX : ETA_POS_MAX;
        end else if (!w_flg.z_neg) begin
            n_eta = (w_mag > MAG_POS_LIM) ? ETA_POS_MAX : w_mag[ETA_W-1:0];
        end else begin
            n_eta = (w_mag > MAG_NEG_LIM) ? ETA_NEG_MAX
                                          : (~w_mag[ETA_W-1:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_r3_out   <= r_r3_dly[N_RAD-1];
        r_rt_out   <= r_rt_dly[N_RAD-1];
        r_az_out   <= n_az_out;
        r_eta_out  <= n_eta;
        r_axis_out <= w_flg.axis;
    end

    assign o_valid             = r_vld[LAT-1];
    assign o_radius_3d         = r_r3_out;
    assign o_radius_transverse = r_rt_out;
    assign o_azimuth           = r_az_out;
    assign o_pseudorapidity    = r_eta_out;
    assign o_on_axis           = r_axis_out;

    // ---------------- assertions ------------------------------------------
    a_axis_phi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_on_axis |-> o_azimuth == AZ_NEG_PI)
        else $error("on-axis beat with azimuth other than -pi");

    a_axis_rt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_on_axis == (o_radius_transverse == '0))
        else $error("on_axis disagrees with transverse radius");

    a_r3_ge_rt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_radius_3d >= o_radius_transverse)
        else $error("3D radius below transverse radius");

    a_axis_eta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_on_axis |-> (o_pseudorapidity == ETA_POS_MAX ||
                                  o_pseudorapidity == ETA_NEG_MAX ||
                                  o_pseudorapidity == '0))
        else $error("on-axis beat with unsaturated eta");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the hit to rho/phi/eta converter: a queue-fed
// driver with random gaps, a bit-exact predictor and an in-order scoreboard.
// ============================================================================
`default_nettype none

module tb_top;
    import crpe_pkg::*;

    localparam int CB      = 20;
    localparam int FB      = 32 - CB;
    localparam int LAT     = 65;
    localparam int WD_LIM  = 4000;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } t_hit;

    typedef struct packed {
        logic [CB-1:0]         r3;
        logic [CB-1:0]         rt;
        logic [AZ_W-1:0]       az;
        logic [ETA_W-1:0]      eta;
        logic                  axis;
    } t_coords;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [CB-1:0]  i_pos_x, i_pos_y, i_pos_z;
    logic                  o_valid;
    logic [CB-1:0]         o_radius_3d, o_radius_transverse;
    logic signed [AZ_W-1:0]  o_azimuth;
    logic signed [ETA_W-1:0] o_pseudorapidity;
    logic                  o_on_axis;

    t_hit    hit_q[$];
    t_coords coords_q[$];
    int      gap_q[$];
    int      n_err, n_in, n_out, idle_cnt;

    cartesian_to_rho_phi_eta_top dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_pos_x, .i_pos_y, .i_pos_z,
        .o_valid, .o_radius_3d, .o_radius_transverse,
        .o_azimuth, .o_pseudorapidity, .o_on_axis
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 with 20 fraction bits by squaring a Q30 mantissa
    function automatic logic [63:0] log2_q20(input logic [63:0] v);
        int e;
        logic [127:0] m;
        logic [63:0] frac;
        if (v == 0) return 0;
        e = 63;
        while (v[e] == 1'b0) e--;
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        frac = 0;
        for (int i = 0; i < 20; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (128'd1 << 31)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << 20) | frac;
    endfunction

    // CORDIC vectoring for phi, angle LSB pi/2^31
    function automatic logic [AZ_W-1:0] phi_of(input longint x, input longint y);
        logic [31:0] acc;
        longint cx, cy, nx, ny;
        if (x == 0 && y == 0) return AZ_NEG_PI;
        acc = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = PI_Q31;
        end
        cx = x <<< (56 - CB);
        cy = y <<< (56 - CB);
        for (int i = 0; i < 16; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                acc = acc + ATAN_TAB[i];
            end else begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                acc = acc - ATAN_TAB[i];
            end
            cx = nx;
            cy = ny;
        end
        acc = acc + 32'h8000;
        return acc[31:16];
    endfunction

    function automatic t_coords hit_to_coords(input t_hit h);
        t_coords c;
        longint x, y, z;
        logic [63:0] ax, ay, az, st, s3, rtf, r3f, r3, rt, la, lr, d, mag;
        logic [127:0] prod;
        x = h.x; y = h.y; z = h.z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        st = ax * ax + ay * ay;
        s3 = st + az * az;
        rtf = isqrt(st << (2 * FB));
        r3f = isqrt(s3 << (2 * FB));
        r3 = r3f >> FB;
        rt = rtf >> FB;
        if (r3 > 64'hFFFFF) r3 = 64'hFFFFF;
        if (rt > 64'hFFFFF) rt = 64'hFFFFF;
        c.r3 = r3[CB-1:0];
        c.rt = rt[CB-1:0];
        c.axis = (x == 0 && y == 0);
        c.az = phi_of(x, y);
        c.eta = 0;
        if (c.axis) begin
            c.eta = (z > 0) ? ETA_POS_MAX : (z < 0) ? ETA_NEG_MAX : '0;
        end else if (z != 0) begin
            la = log2_q20((az << FB) + r3f);
            lr = log2_q20(rtf);
            d = (la > lr) ? la - lr : 0;
            prod = d * 128'(LN2_Q32) + (128'd1 << 39);
            mag = 64'(prod >> 40);
            if (z > 0) c.eta = (mag > 32767) ? 16'h7FFF : mag[15:0];
            else c.eta = -((mag > 32768) ? 16'h8000 : mag[15:0]);
        end
        return c;
    endfunction

    function automatic logic [CB-1:0] rnd_coord();
        case ($urandom_range(0, 9))
            0: return 20'h80000;
            1: return 20'h7FFFF;
            2: return '0;
            3, 4: return 20'($signed($urandom_range(0, 64)) - 32);
            5, 6: return 20'($signed($urandom_range(0, 8192)) - 4096);
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic int rnd_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic add_hit(input logic [CB-1:0] x, y, z);
        hit_q.push_back('{x, y, z});
        gap_q.push_back(rnd_gap());
    endtask

    // Stimulus: directed corners, then random hits; one drain pause midway
    initial begin
        logic [CB-1:0] lim [4];
        lim = '{20'h80000, 20'h7FFFF, 20'h0, 20'h1};
        foreach (lim[i]) add_hit(lim[i], lim[(i + 1) % 4], lim[(i + 2) % 4]);
        add_hit(0, 0, 100);
        add_hit(0, 0, -100);
        add_hit(0, 0, 0);
        add_hit(500, 300, 0);
        add_hit(-500, 0, 7);
        add_hit(-500, 1, -7);
        add_hit(-500, -1, 7);
        add_hit(0, 500, 9);
        add_hit(0, -500, 9);
        add_hit(1, 0, 20'h7FFFF);
        add_hit(1, 0, 20'h80000);
        add_hit(20'h80000, 20'h80000, 20'h80000);
        add_hit(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        add_hit(3, 4, 12);
        add_hit(-3, -4, -12);
        add_hit(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        for (int i = 0; i < 1700; i++) begin
            add_hit(rnd_coord(), rnd_coord(), rnd_coord());
            if (i == 800) gap_q[$] = -1;   // wait for drain before this beat
        end
    end

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            coords_q.push_back(hit_to_coords('{i_pos_x, i_pos_y, i_pos_z}));
            n_in++;
            // back to back: start stays high for the next beat
            if (hit_q.size() > 0 && gap_q[0] == 0) begin
                {i_pos_x, i_pos_y, i_pos_z} <= hit_q.pop_front();
                void'(gap_q.pop_front());
            end else begin
                start <= 1'b0;
            end
        end else if (!start && hit_q.size() > 0) begin
            if (gap_q[0] < 0) begin
                if (coords_q.size() == 0) gap_q[0] = 0;
            end else if (gap_q[0] > 0) begin
                gap_q[0]--;
            end else begin
                {i_pos_x, i_pos_y, i_pos_z} <= hit_q.pop_front();
                void'(gap_q.pop_front());
                start <= 1'b1;
            end
        end
    end

    // Monitor and scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_coords e;
            n_out++;
            if (coords_q.size() == 0) begin
                $error("result beat with no hit outstanding");
                n_err++;
            end else begin
                e = coords_q.pop_front();
                if (o_radius_3d !== e.r3) begin
                    $error("radius_3d exp %0d got %0d", e.r3, o_radius_3d); n_err++;
                end
                if (o_radius_transverse !== e.rt) begin
                    $error("radius_transverse exp %0d got %0d", e.rt, o_radius_transverse);
                    n_err++;
                end
                if (o_azimuth !== e.az) begin
                    $error("azimuth exp %0d got %0d", $signed(e.az), o_azimuth); n_err++;
                end
                if (o_pseudorapidity !== e.eta) begin
                    $error("pseudorapidity exp %0d got %0d", $signed(e.eta),
                           o_pseudorapidity);
                    n_err++;
                end
                if (o_on_axis !== e.axis) begin
                    $error("on_axis exp %0d got %0d", e.axis, o_on_axis); n_err++;
                end
            end
        end
    end

    // Watchdog: cycles with no beat accepted on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIM) begin
            $display("watchdog expired, %0d hits in, %0d results out", n_in, n_out);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        n_err = 0; n_in = 0; n_out = 0; idle_cnt = 0;
        start = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (hit_q.size() == 0 && !start);
        wait (coords_q.size() == 0);
        repeat (LAT + 10) @(posedge i_clk);
        $display("covered %0d hits: axis, zero z, field extremes, all quadrants", n_in);
        $display("%0d result beats checked, %0d mismatches", n_out, n_err);
        if (n_err == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/crpe_pkg.sv
hdl/crpe_sqrt_cell.sv
hdl/crpe_cordic_cell.sv
hdl/crpe_norm_cell.sv
hdl/crpe_log_cell.sv
hdl/cartesian_to_rho_phi_eta_top.sv
tb/sv/tb_top.sv
